### rtl/core/dsf_pkg.sv
`timescale 1ns / 1ps
package dsf_pkg;

  localparam int WORD_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS   = 2'd0,
    CFG_DAMPING     = 2'd1,
    CFG_REST_LENGTH = 2'd2
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] STIFFNESS_RST   = 32'd65536;
  localparam logic [CFG_W-1:0] DAMPING_RST     = 32'd16384;
  localparam logic [CFG_W-1:0] REST_LENGTH_RST = 32'd65536;

  localparam int DIFF_W    = WORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int U_SHIFT   = 30;
  localparam int QUO_W     = U_SHIFT + 1;
  localparam int NUM_W     = DIFF_W + U_SHIFT;
  localparam int FRAC_W    = 16;
  localparam int STRETCH_W = ROOT_W + 2;
  localparam int SMAG_W    = STRETCH_W - 1;
  localparam int PROD_W    = CFG_W + SMAG_W;
  localparam int SCALAR_W  = PROD_W - FRAC_W;
  localparam int SPLIT_W   = SCALAR_W / 2;
  localparam int AXIS_MAG_W = SCALAR_W + QUO_W - U_SHIFT;
  localparam int AXIS_W    = AXIS_MAG_W + 1;
  localparam int FSUM_W    = AXIS_W + 1;
  localparam int DOT_W     = 2 * WORD_W;
  localparam int PROJ_W    = DOT_W - U_SHIFT;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] d;
    logic [5:0][WORD_W-1:0] vel;
  } sq_side_t;

  typedef struct packed {
    logic                   degen;
    logic [2:0]             d_neg;
    logic [ROOT_W-1:0]      root;
    logic [5:0][WORD_W-1:0] vel;
  } div_side_t;

  function automatic logic [WORD_W-1:0] sat_word(input logic signed [FSUM_W-1:0] v);
    logic signed [FSUM_W-1:0] hi;
    logic signed [FSUM_W-1:0] lo;
    hi = FSUM_W'(signed'(2147483647));
    lo = -hi - FSUM_W'(signed'(1));
    if (v > hi) begin
      sat_word = hi[WORD_W-1:0];
    end else if (v < lo) begin
      sat_word = lo[WORD_W-1:0];
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

endpackage

### rtl/core/dsf_spring_if.sv
`timescale 1ns / 1ps
interface dsf_spring_if;
  import dsf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pos_a_x, pos_a_y, pos_a_z;
  logic signed [WORD_W-1:0] pos_b_x, pos_b_y, pos_b_z;
  logic signed [WORD_W-1:0] vel_a_x, vel_a_y, vel_a_z;
  logic signed [WORD_W-1:0] vel_b_x, vel_b_y, vel_b_z;

  modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                  vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, input ready);
  modport sink   (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                  vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, output ready);
endinterface

### rtl/core/dsf_force_if.sv
`timescale 1ns / 1ps
interface dsf_force_if;
  import dsf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] force_a_x, force_a_y, force_a_z;
  logic signed [WORD_W-1:0] force_b_x, force_b_y, force_b_z;
  logic                     degenerate;

  modport source (output valid, force_a_x, force_a_y, force_a_z, force_b_x, force_b_y,
                  force_b_z, degenerate, input ready);
  modport sink   (input valid, force_a_x, force_a_y, force_a_z, force_b_x, force_b_y,
                  force_b_z, degenerate, output ready);
endinterface

### rtl/core/dsf_delay.sv
`timescale 1ns / 1ps
module dsf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] data_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < DEPTH; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) data_q[k] <= data_q[k-1];
    end
  end

  assign valid_o = valid_q[DEPTH-1];
  assign data_o  = data_q[DEPTH-1];
endmodule

### rtl/core/dsf_sqrt.sv
`timescale 1ns / 1ps
module dsf_sqrt #(
  parameter int ROOT_W = dsf_pkg::ROOT_W
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o
);
  // one root bit per stage, restoring digit recurrence
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];
  logic [ROOT_W:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [2*ROOT_W-1:0] rad_in;
    logic [ROOT_W:0]     rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [ROOT_W+1:0]   cand;
    logic [ROOT_W+1:0]   trial;
    logic [ROOT_W+1:0]   diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      cand  = {rem_in[ROOT_W-1:0], rad_in[2*ROOT_W-1 -: 2]};
      trial = {root_in, 2'b01};
      diff  = cand - trial;
      ge    = (cand >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? diff[ROOT_W:0] : cand[ROOT_W:0];
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];
endmodule

### rtl/core/dsf_div.sv
`timescale 1ns / 1ps
module dsf_div #(
  parameter int NUM_W = dsf_pkg::NUM_W,
  parameter int DEN_W = dsf_pkg::ROOT_W,
  parameter int QUO_W = dsf_pkg::QUO_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);
  // quotient must fit QUO_W bits: num_i >> QUO_W below den_i
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [QUO_W-1:0] lo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   cand;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign lo_in  = num_i[QUO_W-1:0];
      assign den_in = den_i;
      assign rem_in = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign quo_in = '0;
    end else begin : g_next
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      cand = {rem_in, lo_in[QUO_W-1]};
      diff = cand - {1'b0, den_in};
      ge   = (cand >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[k]  <= lo_in << 1;
        den_q[k] <= den_in;
        rem_q[k] <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
        quo_q[k] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
endmodule

### rtl/core/dsf_axis.sv
`timescale 1ns / 1ps
module dsf_axis #(
  parameter int SC_W  = dsf_pkg::SCALAR_W,
  parameter int U_W   = dsf_pkg::QUO_W,
  parameter int SPLIT = dsf_pkg::SPLIT_W,
  parameter int SHIFT = dsf_pkg::U_SHIFT
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [SC_W-1:0]                sc_mag_i,
  input  logic                           sc_neg_i,
  input  logic [U_W-1:0]                 u_mag_i,
  input  logic                           u_neg_i,
  output logic signed [SC_W+U_W-SHIFT:0] res_o
);
  // scalar times axis component, truncated toward zero; partial products and result are registered
  localparam int HI_W   = SC_W - SPLIT + U_W;
  localparam int LO_W   = SPLIT + U_W;
  localparam int FULL_W = SC_W + U_W;
  localparam int MAG_W  = FULL_W - SHIFT;

  logic [HI_W-1:0]   p_hi_q;
  logic [LO_W-1:0]   p_lo_q;
  logic              neg_q;
  logic [FULL_W-1:0] full;
  logic [MAG_W-1:0]  mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_hi_q <= HI_W'(sc_mag_i[SC_W-1:SPLIT]) * HI_W'(u_mag_i);
      p_lo_q <= LO_W'(sc_mag_i[SPLIT-1:0]) * LO_W'(u_mag_i);
      neg_q  <= sc_neg_i ^ u_neg_i;
    end
  end

  always_comb begin
    full = {p_hi_q, {SPLIT{1'b0}}} + FULL_W'(p_lo_q);
    mag  = full[FULL_W-1:SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end
endmodule

### rtl/core/damped_spring_force.sv
`timescale 1ns / 1ps
// Damped spring force: one spring record (both endpoint positions and velocities,
// signed Q16.16) per transfer, one force record per transfer, in order. Fully
// pipelined: a new spring is taken every cycle unless a stall on the output holds
// the whole pipeline (3 setup, 33 square-root, 31 divider, 7 multiply/sum stages).
// Registers (stiffness, damping, rest_length) are written through the cfg port;
// the user must do so only while no spring is in flight; this is not enforced.
module damped_spring_force (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dsf_spring_if.sink                    spring_i,
  dsf_force_if.source                   force_o,
  input  logic                          cfg_we_i,
  input  logic [dsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dsf_pkg::CFG_W-1:0]     cfg_data_i
);
  import dsf_pkg::*;

  logic en;
  logic [CFG_W-1:0] stiff_q, damp_q, rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= STIFFNESS_RST;
      damp_q  <= DAMPING_RST;
      rest_q  <= REST_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STIFFNESS:   stiff_q <= cfg_data_i;
        CFG_DAMPING:     damp_q  <= cfg_data_i;
        CFG_REST_LENGTH: rest_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [WORD_W-1:0] pa [3], pb [3], vin [6];
  assign pa[0] = spring_i.pos_a_x;
  assign pa[1] = spring_i.pos_a_y;
  assign pa[2] = spring_i.pos_a_z;
  assign pb[0] = spring_i.pos_b_x;
  assign pb[1] = spring_i.pos_b_y;
  assign pb[2] = spring_i.pos_b_z;
  assign vin[0] = spring_i.vel_a_x;
  assign vin[1] = spring_i.vel_a_y;
  assign vin[2] = spring_i.vel_a_z;
  assign vin[3] = spring_i.vel_b_x;
  assign vin[4] = spring_i.vel_b_y;
  assign vin[5] = spring_i.vel_b_z;

  logic out_valid_q;
  assign en             = !out_valid_q || force_o.ready;
  assign spring_i.ready = en;

  // setup: difference, squares, sum
  logic v0_q, v1_q, v2_q;
  logic signed [DIFF_W-1:0] d0_q [3], d1_q [3], d2_q [3];
  logic [WORD_W-1:0]        vel0_q [6], vel1_q [6], vel2_q [6];
  logic [DIFF_W-1:0]        dmag0 [3];
  logic [SQ_W-1:0]          sq1_q [3];
  logic [SQ_W-1:0]          sum2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag0[i] = d0_q[i][DIFF_W-1] ? DIFF_W'(-d0_q[i]) : DIFF_W'(d0_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d0_q[i]  <= $signed({pb[i][WORD_W-1], pb[i]}) - $signed({pa[i][WORD_W-1], pa[i]});
        d1_q[i]  <= d0_q[i];
        d2_q[i]  <= d1_q[i];
        sq1_q[i] <= SQ_W'(dmag0[i]) * SQ_W'(dmag0[i]);
      end
      for (int k = 0; k < 6; k++) begin
        vel0_q[k] <= vin[k];
        vel1_q[k] <= vel0_q[k];
        vel2_q[k] <= vel1_q[k];
      end
      sum2_q <= sq1_q[0] + sq1_q[1] + sq1_q[2];
    end
  end

  // square root
  sq_side_t          sq_side_in, sq_side_out;
  logic              v3;
  logic [ROOT_W-1:0] dist3;

  always_comb begin
    for (int i = 0; i < 3; i++) sq_side_in.d[i] = d2_q[i];
    for (int k = 0; k < 6; k++) sq_side_in.vel[k] = vel2_q[k];
  end

  dsf_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (sum2_q),
    .root_o(dist3)
  );

  dsf_delay #(.WIDTH($bits(sq_side_t)), .DEPTH(ROOT_W)) u_sq_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v2_q),
    .data_i (sq_side_in),
    .valid_o(v3),
    .data_o (sq_side_out)
  );

  // axis division
  div_side_t         div_side_in, div_side_out;
  logic              v4;
  logic [DIFF_W-1:0] dmag3 [3];
  logic [QUO_W-1:0]  q4 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag3[i] = sq_side_out.d[i][DIFF_W-1] ? DIFF_W'(-sq_side_out.d[i])
                                            : sq_side_out.d[i];
      div_side_in.d_neg[i] = sq_side_out.d[i][DIFF_W-1];
    end
    div_side_in.degen = (dist3 == '0);
    div_side_in.root  = dist3;
    div_side_in.vel   = sq_side_out.vel;
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    dsf_div #(.NUM_W(NUM_W), .DEN_W(ROOT_W), .QUO_W(QUO_W)) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i({dmag3[i], {U_SHIFT{1'b0}}}),
      .den_i(dist3),
      .quo_o(q4[i])
    );
  end

  dsf_delay #(.WIDTH($bits(div_side_t)), .DEPTH(QUO_W)) u_div_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v3),
    .data_i (div_side_in),
    .valid_o(v4),
    .data_o (div_side_out)
  );

  // scalar products
  logic signed [STRETCH_W-1:0] stretch;
  logic [SMAG_W-1:0]           smag;
  logic signed [WORD_W-1:0]    u_s [3];

  always_comb begin
    stretch = $signed({2'b00, div_side_out.root}) - $signed({3'b000, rest_q});
    smag    = stretch[STRETCH_W-1] ? SMAG_W'(-stretch) : stretch[SMAG_W-1:0];
    for (int i = 0; i < 3; i++) begin
      u_s[i] = div_side_out.d_neg[i] ? -$signed({1'b0, q4[i]}) : $signed({1'b0, q4[i]});
    end
  end

  logic                    vm_q [7];
  logic                    dg_q [6];
  logic [QUO_W-1:0]        q1_q [3], q2_q [3], q3_q [3], q4_q [3];
  logic [2:0]              un1_q, un2_q, un3_q, un4_q;
  logic [PROD_W-1:0]       hookp1_q;
  logic                    hneg1_q, hneg2_q;
  logic signed [DOT_W-1:0] vprod1_q [6];
  logic [SCALAR_W-1:0]     hook2_q;
  logic [PROJ_W-1:0]       proj2_q [2];
  logic                    pneg2_q [2], pneg3_q [2], pneg4_q [2];
  logic [PROD_W-1:0]       dvp3_q [2];
  logic [SCALAR_W-1:0]     dv4_q [2];
  logic signed [DOT_W-1:0] dot [2];
  logic [DOT_W-1:0]        dotmag [2];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      dot[e]    = vprod1_q[3*e] + vprod1_q[3*e+1] + vprod1_q[3*e+2];
      dotmag[e] = dot[e][DOT_W-1] ? DOT_W'(-dot[e]) : DOT_W'(dot[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hookp1_q <= PROD_W'(stiff_q) * PROD_W'(smag);
      hneg1_q  <= stretch[STRETCH_W-1];
      for (int k = 0; k < 6; k++) begin
        vprod1_q[k] <= DOT_W'($signed(div_side_out.vel[k])) * DOT_W'(u_s[k % 3]);
      end
      for (int i = 0; i < 3; i++) begin
        q1_q[i] <= q4[i];
        q2_q[i] <= q1_q[i];
        q3_q[i] <= q2_q[i];
        q4_q[i] <= q3_q[i];
      end
      un1_q <= div_side_out.d_neg;
      un2_q <= un1_q;
      un3_q <= un2_q;
      un4_q <= un3_q;
      hook2_q <= hookp1_q[PROD_W-1:FRAC_W];
      hneg2_q <= hneg1_q;
      for (int e = 0; e < 2; e++) begin
        proj2_q[e] <= dotmag[e][DOT_W-1:U_SHIFT];
        pneg2_q[e] <= dot[e][DOT_W-1];
        dvp3_q[e]  <= PROD_W'(damp_q) * PROD_W'(proj2_q[e]);
        pneg3_q[e] <= pneg2_q[e];
        dv4_q[e]   <= dvp3_q[e][PROD_W-1:FRAC_W];
        pneg4_q[e] <= pneg3_q[e];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int s = 0; s < 7; s++) vm_q[s] <= 1'b0;
    end else if (en) begin
      v0_q    <= spring_i.valid;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      vm_q[0] <= v4;
      for (int s = 1; s < 7; s++) vm_q[s] <= vm_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dg_q[0] <= div_side_out.degen;
      for (int s = 1; s < 6; s++) dg_q[s] <= dg_q[s-1];
    end
  end

  // axis scaling
  logic signed [AXIS_W-1:0] hu4 [3];
  logic signed [AXIS_W-1:0] hu5_q [3], hu6_q [3];
  logic signed [AXIS_W-1:0] dmp6 [2][3];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    dsf_axis u_hook (
      .clk_i   (clk_i),
      .en_i    (en),
      .sc_mag_i(hook2_q),
      .sc_neg_i(hneg2_q),
      .u_mag_i (q2_q[i]),
      .u_neg_i (un2_q[i]),
      .res_o   (hu4[i])
    );
    for (genvar e = 0; e < 2; e++) begin : g_end
      dsf_axis u_damp (
        .clk_i   (clk_i),
        .en_i    (en),
        .sc_mag_i(dv4_q[e]),
        .sc_neg_i(pneg4_q[e]),
        .u_mag_i (q4_q[i]),
        .u_neg_i (un4_q[i]),
        .res_o   (dmp6[e][i])
      );
    end
  end

  // output register
  logic [WORD_W-1:0] fa_q [3], fb_q [3];
  logic              degen_q;
  logic signed [FSUM_W-1:0] fa_sum [3], fb_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fa_sum[i] = FSUM_W'(hu6_q[i]) - FSUM_W'(dmp6[0][i]);
      fb_sum[i] = -FSUM_W'(hu6_q[i]) - FSUM_W'(dmp6[1][i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hu5_q[i] <= hu4[i];
        hu6_q[i] <= hu5_q[i];
        fa_q[i]  <= dg_q[5] ? '0 : sat_word(fa_sum[i]);
        fb_q[i]  <= dg_q[5] ? '0 : sat_word(fb_sum[i]);
      end
      degen_q <= dg_q[5];
    end
  end

  assign out_valid_q = vm_q[6];

  assign force_o.valid      = out_valid_q;
  assign force_o.force_a_x  = fa_q[0];
  assign force_o.force_a_y  = fa_q[1];
  assign force_o.force_a_z  = fa_q[2];
  assign force_o.force_b_x  = fb_q[0];
  assign force_o.force_b_y  = fb_q[1];
  assign force_o.force_b_z  = fb_q[2];
  assign force_o.degenerate = degen_q;
endmodule

### rtl/core/dsf_checker.sv
`timescale 1ns / 1ps
module dsf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [dsf_pkg::WORD_W-1:0]  fax_i,
  input logic [dsf_pkg::WORD_W-1:0]  fay_i,
  input logic [dsf_pkg::WORD_W-1:0]  faz_i,
  input logic [dsf_pkg::WORD_W-1:0]  fbx_i,
  input logic [dsf_pkg::WORD_W-1:0]  fby_i,
  input logic [dsf_pkg::WORD_W-1:0]  fbz_i,
  input logic                        degen_i
);
  import dsf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fax_i) && $stable(fay_i) &&
    $stable(faz_i) && $stable(fbx_i) && $stable(fby_i) && $stable(fbz_i) && $stable(degen_i))
    else $error("output transfer changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degen_i |-> fax_i == '0 && fay_i == '0 && faz_i == '0 &&
    fbx_i == '0 && fby_i == '0 && fbz_i == '0)
    else $error("degenerate spring with nonzero force");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output slot");
endmodule

bind damped_spring_force dsf_checker u_dsf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (spring_i.ready),
  .out_valid_i(force_o.valid),
  .out_ready_i(force_o.ready),
  .fax_i      (force_o.force_a_x),
  .fay_i      (force_o.force_a_y),
  .faz_i      (force_o.force_a_z),
  .fbx_i      (force_o.force_b_x),
  .fby_i      (force_o.force_b_y),
  .fbz_i      (force_o.force_b_z),
  .degen_i    (force_o.degenerate)
);
